// ----- hw/rtl/pss_pkg.sv -----
// Shared types and constants for the polygon support point core.
`default_nettype none
package pss_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 32;
    localparam int ROT_W   = 16;
    localparam int VCNT_W  = 5;
    localparam int IDX_W   = 4;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int Q_FRAC  = 14;
    localparam int ROT_MSB = COORD_W + ROT_W;
    localparam int SUM_W   = ROT_MSB - Q_FRAC + 2;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT  = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/polygon_support_point_core.sv -----
// Top level: vertex table, query sequencer and result register.
// A query walks the n vertices in use (n is clamped to at most 16) in turn and then
// presents its result; if n is 0, the empty result is valid the cycle after acceptance.
// One query is taken at a time; each vertex takes ten sequencer steps on the single
// shared multiplier and accumulator. Ready returns the cycle after the result is taken.
// Reset (synchronous, active low) sets control and config registers to defaults; the
// datapath and vertex table keep no reset; the table holds garbage until written.
`default_nettype none
module polygon_support_point_core
    import pss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [3:0] index, [35:4] coord_x, [67:36] coord_y, [71:68] zero
    input  wire logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // [0] cmd
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [31:0] support_x, [63:32] support_y
    output logic      [M_DATA_W-1:0]   o_m_axis_tdata,
    // [0] empty_res
    output logic                       o_m_axis_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_RD   = 12'b0000_0000_0010,
        ST_MCX  = 12'b0000_0000_0100,
        ST_MSY  = 12'b0000_0000_1000,
        ST_MSX  = 12'b0000_0001_0000,
        ST_MCY  = 12'b0000_0010_0000,
        ST_MDX  = 12'b0000_0100_0000,
        ST_MDY  = 12'b0000_1000_0000,
        ST_MDM  = 12'b0001_0000_0000,
        ST_DOT  = 12'b0010_0000_0000,
        ST_CMP  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_pos_x, r_pos_y;
    logic signed [ROT_W-1:0]   r_rot_cos, r_rot_sin;
    logic        [VCNT_W-1:0]  r_vcount;

    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_have, n_have;
    logic             r_empty, n_empty;

    logic signed [COORD_W-1:0] r_dir_x, n_dir_x, r_dir_y, n_dir_y;
    logic signed [COORD_W-1:0] r_tx, n_tx, r_ty, n_ty;
    logic signed [COORD_W-1:0] r_best_x, n_best_x, r_best_y, n_best_y;
    logic signed [ACC_W-1:0]   r_best, n_best;

    logic                      in_req, out_req, is_query;
    logic [IDX_W-1:0]          in_index;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic [CNT_W-1:0]          clamp_n, idx_inc;

    logic                      ram_we, ram_re;
    logic [2*COORD_W-1:0]      ram_rdata;
    logic signed [COORD_W-1:0] vx, vy;

    t_mac_ctl                  mac_ctl;
    logic signed [COORD_W-1:0] op_a, op_b, mac_offset, mac_sat;
    logic signed [ACC_W-1:0]   mac_acc;
    logic                      better;

    assign in_index = i_s_axis_tdata[IDX_W-1:0];
    assign in_x     = i_s_axis_tdata[IDX_W+COORD_W-1:IDX_W];
    assign in_y     = i_s_axis_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W];
    assign is_query = (i_s_axis_tuser == CMD_QUERY);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_cfg_ready     = 1'b1;
    assign in_req  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_req = o_m_axis_tvalid && i_m_axis_tready;

    assign clamp_n = (32'(r_vcount) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(r_vcount);
    assign idx_inc = r_idx + CNT_W'(1);

    assign ram_we = in_req && !is_query && (32'(in_index) < MAX_VERTICES);
    assign ram_re = (r_state == ST_RD);
    assign vx = ram_rdata[COORD_W-1:0];
    assign vy = ram_rdata[2*COORD_W-1:COORD_W];

    pss_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (VIDX_W'(in_index)),
        .i_wdata ({in_y, in_x}),
        .i_re    (ram_re),
        .i_raddr (r_idx[VIDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    pss_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_offset (mac_offset),
        .o_acc    (mac_acc),
        .o_sat    (mac_sat)
    );

    assign mac_offset = (r_state == ST_MCY) ? r_pos_x : r_pos_y;
    assign better     = !r_have || (mac_acc > r_best);

    // operand select and accumulate op per step
    always_comb begin
        mac_ctl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
        op_a    = COORD_W'(r_rot_cos);
        op_b    = vx;
        case (r_state)
            ST_MCX: begin
                mac_ctl.mul_en = 1'b1;
            end
            ST_MSY: begin
                mac_ctl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
                op_a    = COORD_W'(r_rot_sin);
                op_b    = vy;
            end
            ST_MSX: begin
                mac_ctl = '{mul_en: 1'b1, acc_op: ACC_SUB};
                op_a    = COORD_W'(r_rot_sin);
            end
            ST_MCY: begin
                mac_ctl = '{mul_en: 1'b1, acc_op: ACC_LOAD};
                op_b    = vy;
            end
            ST_MDX: begin
                mac_ctl = '{mul_en: 1'b1, acc_op: ACC_ADD};
                op_a    = r_tx;
                op_b    = r_dir_x;
            end
            ST_MDY: begin
                mac_ctl.acc_op = ACC_LOAD;
            end
            ST_MDM: begin
                mac_ctl.mul_en = 1'b1;
                op_a           = r_ty;
                op_b           = r_dir_y;
            end
            ST_DOT: begin
                mac_ctl.acc_op = ACC_ADD;
            end
            default: begin
                mac_ctl = '{mul_en: 1'b0, acc_op: ACC_HOLD};
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_n      = r_n;
        n_have   = r_have;
        n_empty  = r_empty;
        n_dir_x  = r_dir_x;
        n_dir_y  = r_dir_y;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_best   = r_best;
        n_best_x = r_best_x;
        n_best_y = r_best_y;
        case (r_state)
            ST_IDLE: begin
                if (in_req && is_query) begin
                    n_dir_x  = in_x;
                    n_dir_y  = in_y;
                    n_n      = clamp_n;
                    n_idx    = '0;
                    n_have   = 1'b0;
                    n_best_x = '0;
                    n_best_y = '0;
                    n_empty  = (clamp_n == '0);
                    n_state  = (clamp_n == '0) ? ST_OUT : ST_RD;
                end
            end
            ST_RD:  n_state = ST_MCX;
            ST_MCX: n_state = ST_MSY;
            ST_MSY: n_state = ST_MSX;
            ST_MSX: n_state = ST_MCY;
            ST_MCY: begin
                n_tx    = mac_sat;
                n_state = ST_MDX;
            end
            ST_MDX: n_state = ST_MDY;
            ST_MDY: begin
                n_ty    = mac_sat;
                n_state = ST_MDM;
            end
            ST_MDM: n_state = ST_DOT;
            ST_DOT: n_state = ST_CMP;
            ST_CMP: begin
                if (better) begin
                    n_have   = 1'b1;
                    n_best   = mac_acc;
                    n_best_x = r_tx;
                    n_best_y = r_ty;
                end
                n_idx   = idx_inc;
                n_state = (idx_inc == r_n) ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (out_req) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_n       <= '0;
            r_have    <= 1'b0;
            r_empty   <= 1'b0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_rot_cos <= ROT_ONE;
            r_rot_sin <= '0;
            r_vcount  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_n     <= n_n;
            r_have  <= n_have;
            r_empty <= n_empty;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POS_X:   r_pos_x   <= i_cfg_data;
                    CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                    CFG_ROT_COS: r_rot_cos <= i_cfg_data[ROT_W-1:0];
                    CFG_ROT_SIN: r_rot_sin <= i_cfg_data[ROT_W-1:0];
                    CFG_VCOUNT:  r_vcount  <= i_cfg_data[VCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dir_x  <= n_dir_x;
        r_dir_y  <= n_dir_y;
        r_tx     <= n_tx;
        r_ty     <= n_ty;
        r_best   <= n_best;
        r_best_x <= n_best_x;
        r_best_y <= n_best_y;
    end

    assign o_m_axis_tdata = {r_best_y, r_best_x};
    assign o_m_axis_tuser = r_empty;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_n)
        else $error("vertex counter past vertex count");

    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_req && is_query && clamp_n == '0) |=> (o_m_axis_tvalid && o_m_axis_tuser))
        else $error("empty query did not answer next cycle");

    a_result_had_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> r_have)
        else $error("non-empty result without any vertex compared");

    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_req |=> o_s_axis_tready)
        else $error("not ready after result was taken");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("vertex table written during a query");

endmodule
`default_nettype wire

// ----- hw/rtl/pss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pss_mac.sv -----
// Shared multiply-accumulate unit with Q14 floor, offset add and saturation.
`default_nettype none
module pss_mac
    import pss_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_mac_ctl                   i_ctl,
    input  wire logic signed [COORD_W-1:0]  i_op_a,
    input  wire logic signed [COORD_W-1:0]  i_op_b,
    input  wire logic signed [COORD_W-1:0]  i_offset,
    output logic signed      [ACC_W-1:0]    o_acc,
    output logic signed      [COORD_W-1:0]  o_sat
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  sum;

    assign prod_ext = {r_prod[PROD_W-1], r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        case (i_ctl.acc_op)
            ACC_LOAD: r_acc <= prod_ext;
            ACC_ADD:  r_acc <= r_acc + prod_ext;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    // arithmetic shift of the exact rotation sum is the floor division
    assign sum = {r_acc[ROT_MSB], r_acc[ROT_MSB:Q_FRAC]}
               + {{(SUM_W-COORD_W){i_offset[COORD_W-1]}}, i_offset};

    always_comb begin
        if (sum[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b0}} ||
            sum[SUM_W-1:COORD_W-1] == {(SUM_W-COORD_W+1){1'b1}}) begin
            o_sat = sum[COORD_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            o_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire
